FILE: hdl/cct_pkg.sv
// Shared types and constants for the cycle counter time offset block.
// No dependencies; used by cct_div, cycle_counter_time_offset_top and tb_top.
package cct_pkg;

  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned UPJ_W     = 20;
  localparam int unsigned WORD_W    = 32;

  localparam logic [UPJ_W-1:0] UPJ_RESET = 20'd10000;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } cct_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } cct_div_rsp_t;

endpackage

FILE: hdl/cycle_counter_time_offset_top.sv
// Interpolates microseconds since the last timer tick from a 32-bit cycle
// counter. A tick item updates the stored counter state and leaves the input
// ready. A query item whose tick count is nonzero and differs from the last
// one seen recomputes the reciprocal with two 64-bit divisions on one shared
// divider, the second skipped when cycles per tick is zero. The input is not
// ready while a query is in progress. The result waits in an output register;
// the next item is taken while it is pending.
// Depends on cct_pkg and cct_div.
module cycle_counter_time_offset_top
  import cct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,   // tick period in microseconds
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // [31:0] counter_value, [63:32] jiffy_count
  input  logic        in_tuser,      // kind: 0 tick, 1 query
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata      // [19:0] offset_usec, [23:20] zero
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV1, ST_DIV2, ST_MUL, ST_CLAMP, ST_OUT
  } state_t;

  state_t              state_r;
  logic [UPJ_W-1:0]    upj_r;
  logic [WORD_W-1:0]   cycles_high_r;
  logic [WORD_W-1:0]   cycles_low_r;
  logic [WORD_W-1:0]   last_tick_r;
  logic [WORD_W-1:0]   recip_r;
  logic [WORD_W-1:0]   sample_r;
  logic [2*WORD_W-1:0] prod_r;
  logic [UPJ_W-1:0]    res_r;
  logic [UPJ_W-1:0]    out_res_r;
  logic                out_valid_r;

  logic [WORD_W-1:0]   in_sample;
  logic [WORD_W-1:0]   in_ticks;
  logic                in_fire;
  logic                need_recip;
  logic [WORD_W-1:0]   high_bump;
  logic [WORD_W-1:0]   delta;
  logic [WORD_W-1:0]   prod_hi;
  logic                out_load;
  cct_div_req_t        div_req;
  cct_div_rsp_t        div_rsp;

  assign in_sample  = in_tdata[WORD_W-1:0];
  assign in_ticks   = in_tdata[2*WORD_W-1:WORD_W];
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign need_recip = (in_ticks != '0) && (in_ticks != last_tick_r);
  assign high_bump  = (in_sample < cycles_low_r) ? cycles_high_r + 1'b1 : cycles_high_r;
  assign delta      = sample_r - cycles_low_r;
  assign prod_hi    = prod_r[2*WORD_W-1:WORD_W];
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {cycles_high_r, cycles_low_r};
    div_req.divisor  = {{WORD_W{1'b0}}, in_ticks};
    case (state_r)
      ST_IDLE: begin
        div_req.start = in_fire && (in_tuser == KIND_QUERY) && need_recip;
      end
      ST_DIV1: begin
        // second pass: (tick period << 32) / cycles per tick
        div_req.start    = div_rsp.done && (div_rsp.quotient != '0);
        div_req.dividend = {{(DIV_W-UPJ_W-WORD_W){1'b0}}, upj_r, {WORD_W{1'b0}}};
        div_req.divisor  = div_rsp.quotient;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  cct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      upj_r         <= UPJ_RESET;
      cycles_high_r <= '0;
      cycles_low_r  <= '0;
      last_tick_r   <= '0;
      recip_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        upj_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res_r;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_tuser == KIND_TICK) begin
              if (in_ticks == '0) begin
                cycles_high_r <= '0;
                cycles_low_r  <= '0;
              end else begin
                cycles_high_r <= high_bump;
                cycles_low_r  <= in_sample;
              end
            end else begin
              sample_r <= in_sample;
              if (need_recip) begin
                last_tick_r <= in_ticks;
                state_r     <= ST_DIV1;
              end else begin
                state_r <= ST_MUL;
              end
            end
          end
        end
        ST_DIV1: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient == '0) begin
              recip_r <= '1;
              state_r <= ST_MUL;
            end else begin
              state_r <= ST_DIV2;
            end
          end
        end
        ST_DIV2: begin
          if (div_rsp.done) begin
            recip_r <= div_rsp.quotient[WORD_W-1:0];
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= delta * recip_r;
          state_r <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (upj_r == '0) begin
            res_r <= '0;
          end else if (prod_hi >= {{(WORD_W-UPJ_W){1'b0}}, upj_r}) begin
            res_r <= upj_r - 1'b1;
          end else begin
            res_r <= prod_hi[UPJ_W-1:0];
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // out_res_r holds the pending item while the next query runs
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24-UPJ_W){1'b0}}, out_res_r};

endmodule

FILE: hdl/cct_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on cct_pkg. Divisor is never zero when started.
module cct_div
  import cct_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cct_div_req_t req,
  output cct_div_rsp_t rsp
);

  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       diff;
  logic                 take;

  // partial remainder shifted left with the next dividend bit
  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign take    = !diff[DIV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], take};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for cycle_counter_time_offset_top: tick and query items,
// an in-bench interpolation predictor and a scoreboard on the offset results.
// Depends on cct_pkg and the block's RTL.
module tb_top;
  import cct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_TAIL  = 200;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic        kind;
    logic [31:0] counter;
    logic [31:0] jiffies;
  } tick_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [19:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  tick_item_t  item_q[$];
  logic [19:0] offset_exp_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        calm = 1'b0;

  // predictor copy of the block's state
  logic [19:0] m_upj;
  logic [31:0] m_high, m_low, m_last, m_recip;

  // generator state for well-formed tick/query sequences
  logic [31:0] gen_cnt, gen_jiffy, gen_cpt;

  cycle_counter_time_offset_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [31:0] counter_value, [63:32] jiffy_count
    .in_tuser   (in_tuser),     // kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)     // [19:0] offset_usec, [23:20] zero
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit interp_offset(input tick_item_t it, output logic [19:0] usec);
    logic [63:0] total, per_tick, prod;
    logic [31:0] delta;
    usec = '0;
    if (it.kind == KIND_TICK) begin
      if (it.counter < m_low) m_high = m_high + 32'd1;
      m_low = it.counter;
      if (it.jiffies == '0) begin
        m_high = '0;
        m_low  = '0;
      end
      return 1'b0;
    end
    if (it.jiffies != '0 && it.jiffies != m_last) begin
      m_last   = it.jiffies;
      total    = {m_high, m_low};
      per_tick = total / {32'd0, it.jiffies};
      if (per_tick == '0) m_recip = '1;
      else m_recip = 32'({12'd0, m_upj, 32'd0} / per_tick);
    end
    delta = it.counter - m_low;
    prod  = {32'd0, delta} * {32'd0, m_recip};
    if (m_upj == '0) usec = '0;
    else if (prod[63:32] >= {12'd0, m_upj}) usec = m_upj - 20'd1;
    else usec = prod[51:32];
    return 1'b1;
  endfunction

  // prediction at the accepting edge; config tracked at the same edge
  always @(posedge clk) begin : predict
    tick_item_t  acc;
    logic [19:0] usec;
    if (rst_n) begin
      if (cfg_wr_en) m_upj = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        acc.kind    = in_tuser;
        acc.counter = in_tdata[31:0];
        acc.jiffies = in_tdata[63:32];
        if (interp_offset(acc, usec)) offset_exp_q.push_back(usec);
      end
    end
  end

  always @(posedge clk) begin : drive
    tick_item_t nxt;
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (item_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
        nxt = item_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.kind;
        in_tdata  <= {nxt.jiffies, nxt.counter};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    logic [19:0] want;
    if (rst_n) begin
      out_tready <= calm || ($urandom_range(99) >= 8);
      if (out_tvalid && out_tready) begin
        if (offset_exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result offset_usec=%0d", out_tdata[19:0]);
        end else begin
          want = offset_exp_q.pop_front();
          if (out_tdata !== {4'd0, want}) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("offset mismatch: expected %0d got %0d (tdata %h)",
                       want, out_tdata[19:0], out_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic tick_item_t mk(logic kind, logic [31:0] cnt, logic [31:0] jif);
    tick_item_t it;
    it.kind    = kind;
    it.counter = cnt;
    it.jiffies = jif;
    return it;
  endfunction

  task automatic write_upj(input logic [19:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ticks give no result, so the drain does not end as soon as the queues are empty
  task automatic drain();
    while (item_q.size() != 0 || in_tvalid || offset_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic random_items(input int unsigned n);
    int unsigned r;
    gen_cpt = $urandom_range(1, 32'd1 << $urandom_range(1, 30));
    gen_cnt = $urandom;
    // sometimes start close to a tick count wrap
    gen_jiffy = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(20) : $urandom_range(50);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 12) begin
        item_q.push_back(mk($urandom_range(1), $urandom,
                            ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom));
      end else if (r < 55) begin
        gen_jiffy = gen_jiffy + 32'd1;
        gen_cnt   = gen_cnt + gen_cpt + 32'($urandom_range(gen_cpt / 16));
        item_q.push_back(mk(KIND_TICK, gen_cnt, gen_jiffy));
      end else begin
        item_q.push_back(mk(KIND_QUERY,
                            gen_cnt + 32'($urandom_range(gen_cpt + gen_cpt / 4)), gen_jiffy));
      end
    end
  endtask

  initial begin
    m_upj = UPJ_RESET;
    m_high = '0; m_low = '0; m_last = '0; m_recip = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_upj(20'd10000);
    item_q.push_back(mk(KIND_QUERY, 32'd1000, 32'd1));        // query before any tick
    item_q.push_back(mk(KIND_QUERY, 32'hFFFF_FFFF, 32'd0));   // tick count zero
    item_q.push_back(mk(KIND_TICK, 32'd100000, 32'd2));
    item_q.push_back(mk(KIND_TICK, 32'd200000, 32'd3));
    item_q.push_back(mk(KIND_QUERY, 32'd250000, 32'd3));
    item_q.push_back(mk(KIND_QUERY, 32'd260000, 32'd3));      // cached reciprocal
    item_q.push_back(mk(KIND_TICK, 32'hFFFF_FFF0, 32'd4));
    item_q.push_back(mk(KIND_TICK, 32'h0000_0010, 32'd5));    // counter wrap
    item_q.push_back(mk(KIND_QUERY, 32'h0000_0020, 32'd5));
    item_q.push_back(mk(KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    item_q.push_back(mk(KIND_TICK, 32'h1234_5678, 32'd0));    // tick count wrapped: clear
    item_q.push_back(mk(KIND_QUERY, 32'd5, 32'd0));
    item_q.push_back(mk(KIND_QUERY, 32'd0, 32'd7));           // zero divisor
    item_q.push_back(mk(KIND_TICK, 32'd3, 32'd1));
    item_q.push_back(mk(KIND_QUERY, 32'd4, 32'd1));           // reciprocal overflows 32 bits
    item_q.push_back(mk(KIND_QUERY, 32'd1, 32'd1));           // count below last sample
    item_q.push_back(mk(KIND_QUERY, 32'hFFFF_FFFF, 32'h8000_0000));
    item_q.push_back(mk(KIND_TICK, 32'hAAAA_5555, 32'h5555_AAAA));
    item_q.push_back(mk(KIND_QUERY, 32'hFFFF_0000, 32'hAAAA_5555));
    drain();

    write_upj(20'd0);
    item_q.push_back(mk(KIND_TICK, 32'd1000, 32'd10));
    item_q.push_back(mk(KIND_QUERY, 32'd900000, 32'd11));
    item_q.push_back(mk(KIND_QUERY, 32'hFFFF_FFFF, 32'd11));
    random_items(40);
    drain();

    write_upj(20'd1);
    random_items(80);
    drain();

    write_upj(20'd1000000);
    calm = 1'b1;
    random_items(90);
    drain();
    calm = 1'b0;

    write_upj(20'hFFFFF);
    random_items(90);
    drain();

    write_upj(20'd10000);
    random_items(100);
    drain();

    write_upj(20'($urandom_range(1, 1000000)));
    random_items(90);
    drain();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/cct_pkg.sv
hdl/cct_div.sv
hdl/cycle_counter_time_offset_top.sv
dv/tb_top.sv
